/* hdl/assert_macros.svh */
// assertion macros used by the estimator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/tme_pkg.sv */
// types and constants of the thrust mass estimator
`default_nettype none
package tme_pkg;
    localparam int MAX_SAMPLES = 64;
    localparam int MAX_BATCH   = 256;
    localparam int FRAC_BITS   = 16;

    localparam int ACCEL_W  = 24;
    localparam int THRUST_W = 28;
    localparam int MASS_W   = 28;
    localparam int GAIN_W   = 17;
    localparam int WIN_W    = 7;
    localparam int CFG_W    = 28;
    localparam int CFG_IDX_W = 2;

    localparam int HIST_AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int FILL_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W   = $clog2(MAX_BATCH + 1);
    localparam int SUM_W   = ACCEL_W + CNT_W;
    localparam int SCALE_W = CNT_W + FRAC_BITS;
    localparam int WSUM_W  = MASS_W + FILL_W;

    // divider sizes: batch numerator thrust*count*2^frac over |sum|
    localparam int DIV_NUM_W = (THRUST_W - 1) + CNT_W + FRAC_BITS;
    localparam int DIV_DEN_W = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // mean must exceed one millionth
    localparam int MEAN_LIMIT   = 1000000;
    localparam int MEAN_LIMIT_W = 20;
    localparam int PROD_W       = SUM_W + MEAN_LIMIT_W;

    // low-pass gain in Q1.16
    localparam int GAIN_SH = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam int FACC_W  = GAIN_W + MASS_W;

    localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};
    localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_MASS = 2'd0,
        CFG_THRESHOLD    = 2'd1,
        CFG_GAIN         = 2'd2,
        CFG_WINDOW       = 2'd3
    } t_cfg_idx;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_TEST  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_BOUT  = 9'b000010000,
        S_RSUM  = 9'b000100000,
        S_RDIV  = 9'b001000000,
        S_FILT1 = 9'b010000000,
        S_FILT2 = 9'b100000000
    } t_state;
endpackage
`default_nettype wire

/* hdl/tme_in_if.sv */
// input channel: acceleration samples and read requests
`default_nettype none
interface tme_in_if import tme_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [ACCEL_W-1:0]  accel;
    logic signed [THRUST_W-1:0] thrust;
    logic                       batch_end;

    modport source (output valid, mode, accel, thrust, batch_end, input ready);
    modport sink (input valid, mode, accel, thrust, batch_end, output ready);
endinterface
`default_nettype wire

/* hdl/tme_out_if.sv */
// output channel: mass results
`default_nettype none
interface tme_out_if import tme_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [MASS_W-1:0] mass;
    logic              accepted;

    modport source (output valid, kind, mass, accepted, input ready);
    modport sink (input valid, kind, mass, accepted, output ready);
endinterface
`default_nettype wire

/* hdl/tme_div.sv */
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module tme_div import tme_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [DIV_NUM_W-1:0]      o_quo
);
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_sh;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 take;

    // one shift-subtract step
    assign trial = {r_rem, r_sh[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
                r_den  <= i_den;
                r_rem  <= '0;
                r_sh   <= i_num;
            end else if (r_busy) begin
                r_rem <= take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_sh  <= {r_sh[DIV_NUM_W-2:0], take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_sh;
endmodule
`default_nettype wire

/* hdl/thrust_mass_estimator.sv */
// thrust mass estimator top level: batch averaging, history ring, filtered reads
//
//  channel  dir  carries
//  i_in     in   mode, accel, thrust, batch_end
//  o_out    out  kind, mass, accepted
//  i_cfg_*  in   register writes, index 0..3
//
// a sample without batch end is summed and the sequencer stays idle
// a batch end runs the mean test and, if it passes, the 52-step shared divider
// a read sums n history entries, read one per cycle
// from the ring memory, then the same divider if n > 0 and two filter multiplies
// a result waits in the output register; samples are still taken meanwhile
// synchronous active-low reset; the ring holds no reset contents
`default_nettype none
`include "assert_macros.svh"
module thrust_mass_estimator import tme_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tme_in_if.sink                    i_in,
    tme_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    t_state r_state, n_state;

    // configuration
    logic signed [CFG_W-1:0]    r_thresh;
    logic [GAIN_W-1:0]          r_gain;
    logic [WIN_W-1:0]           r_window;

    // estimator state
    logic signed [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]           r_count;
    logic [MASS_W-1:0]          r_held;
    logic [MASS_W-1:0]          r_smooth;
    logic [HIST_AW-1:0]         r_head;
    logic [FILL_W-1:0]          r_fill;
    logic [MASS_W-1:0]          r_hist [MAX_SAMPLES];
    logic [MASS_W-1:0]          r_rdata;

    // work registers
    logic signed [THRUST_W-1:0] r_thrust;
    logic [DIV_DEN_W-1:0]       r_mag;
    logic [DIV_NUM_W-1:0]       r_num;
    logic                       r_pos;
    logic [MASS_W-1:0]          r_res;
    logic                       r_res_acc;
    logic [HIST_AW-1:0]         r_idx;
    logic [FILL_W-1:0]          r_left;
    logic [FILL_W-1:0]          r_nwin;
    logic                       r_pend;
    logic [WSUM_W-1:0]          r_wsum;
    logic [MASS_W-1:0]          r_avg;
    logic [FACC_W-1:0]          r_facc;

    // output register
    logic                       r_out_valid;
    logic                       r_out_kind;
    logic [MASS_W-1:0]          r_out_mass;
    logic                       r_out_acc;

    logic                       in_acc;
    logic                       out_free;
    logic                       out_load;
    logic                       test_ok;
    logic                       rsum_done;
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [DIV_NUM_W-1:0]       div_num;
    logic [DIV_DEN_W-1:0]       div_den;
    logic [DIV_NUM_W-1:0]       div_quo;
    logic [MASS_W-1:0]          quo_sat;
    logic [MASS_W-1:0]          mass_diff;
    logic                       upd_ok;
    logic [PROD_W-1:0]          mean_prod;
    logic [SCALE_W-1:0]         scale;
    logic [FILL_W-1:0]          win_n;
    logic [GAIN_W-1:0]          gain_c;
    logic [HIST_AW-1:0]         rd_addr;
    logic [HIST_AW-1:0]         head_inc;
    logic                       hist_we;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ((r_state == S_BOUT) || (r_state == S_FILT2)) && out_free;
    assign i_in.ready = (r_state == S_IDLE);

    // mean magnitude test against one millionth
    assign scale     = {r_count, {FRAC_BITS{1'b0}}};
    assign mean_prod = PROD_W'(r_mag) * PROD_W'(MEAN_LIMIT);
    assign test_ok   = r_pos && (r_mag != '0) && (mean_prod > PROD_W'(scale));

    // quotient saturation and threshold decision
    assign quo_sat   = (|div_quo[DIV_NUM_W-1:MASS_W]) ? MASS_MAX : div_quo[MASS_W-1:0];
    assign mass_diff = (quo_sat > r_held) ? quo_sat - r_held : r_held - quo_sat;
    assign upd_ok    = !r_thresh[CFG_W-1] &&
                       ((MASS_W+1)'(mass_diff) > (MASS_W+1)'(unsigned'(r_thresh)));

    assign win_n  = (FILL_W'(r_window) < r_fill) ? FILL_W'(r_window) : r_fill;
    assign gain_c = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;

    assign rsum_done = (r_left == '0) && !r_pend;
    assign rd_addr   = (r_idx == '0) ? HIST_AW'(MAX_SAMPLES - 1) : r_idx - 1'b1;
    assign head_inc  = (r_head == HIST_AW'(MAX_SAMPLES - 1)) ? '0 : r_head + 1'b1;
    assign hist_we   = (r_state == S_BOUT) && out_free;

    // shared divider, batch mass or window average
    assign div_start = ((r_state == S_TEST) && test_ok) ||
                       ((r_state == S_RSUM) && rsum_done && (r_nwin != '0));
    assign div_num   = (r_state == S_TEST) ? r_num : DIV_NUM_W'(r_wsum);
    assign div_den   = (r_state == S_TEST) ? r_mag : DIV_DEN_W'(r_nwin);

    tme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode) n_state = S_RSUM;
                    else if (i_in.batch_end) n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = S_TEST;
            S_TEST:  n_state = test_ok ? S_DIV : S_BOUT;
            S_DIV:   if (div_done) n_state = S_BOUT;
            S_BOUT:  if (out_free) n_state = S_IDLE;
            S_RSUM: begin
                if (rsum_done) n_state = (r_nwin != '0) ? S_RDIV : S_FILT1;
            end
            S_RDIV:  if (div_done) n_state = S_FILT1;
            S_FILT1: n_state = S_FILT2;
            S_FILT2: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // history ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (hist_we) r_hist[r_head] <= r_res;
        r_rdata <= r_hist[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thresh    <= '0;
            r_gain      <= GAIN_ONE;
            r_window    <= WIN_W'(16);
            r_sum       <= '0;
            r_count     <= '0;
            r_held      <= MASS_RESET;
            r_smooth    <= MASS_RESET;
            r_head      <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // output beat register
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.mode) begin
                            r_left <= win_n;
                            r_nwin <= win_n;
                            r_idx  <= r_head;
                            r_wsum <= '0;
                            r_pend <= 1'b0;
                            r_head <= '0;
                            r_fill <= '0;
                        end else begin
                            if (r_count < CNT_W'(MAX_BATCH)) begin
                                r_sum   <= r_sum + SUM_W'(i_in.accel);
                                r_count <= r_count + 1'b1;
                            end
                            r_thrust <= i_in.thrust;
                        end
                    end
                end
                // magnitude and numerator for the batch quotient
                S_CHECK: begin
                    r_mag <= r_sum[SUM_W-1] ? DIV_DEN_W'(-r_sum) : DIV_DEN_W'(r_sum);
                    r_num <= {(THRUST_W-1+CNT_W)'(r_thrust[THRUST_W-2:0]) *
                              (THRUST_W-1+CNT_W)'(r_count), {FRAC_BITS{1'b0}}};
                    r_pos <= (r_thrust > 0) && (r_count != '0);
                end
                S_TEST: begin
                    if (!test_ok) begin
                        r_res     <= r_held;
                        r_res_acc <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (upd_ok) begin
                            r_res     <= quo_sat;
                            r_held    <= quo_sat;
                            r_res_acc <= 1'b1;
                        end else begin
                            r_res     <= r_held;
                            r_res_acc <= 1'b0;
                        end
                    end
                end
                // push to history and present the batch beat
                S_BOUT: begin
                    if (out_free) begin
                        r_head <= head_inc;
                        if (r_fill < FILL_W'(MAX_SAMPLES)) r_fill <= r_fill + 1'b1;
                        r_sum       <= '0;
                        r_count     <= '0;
                        r_out_kind  <= 1'b0;
                        r_out_mass  <= r_res;
                        r_out_acc   <= r_res_acc;
                    end
                end
                // walk back from the head, one entry a cycle
                S_RSUM: begin
                    if (r_pend) r_wsum <= r_wsum + WSUM_W'(r_rdata);
                    if (r_left != '0) begin
                        r_idx  <= rd_addr;
                        r_left <= r_left - 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (rsum_done && (r_nwin == '0)) r_avg <= '0;
                end
                S_RDIV: begin
                    if (div_done) r_avg <= div_quo[MASS_W-1:0];
                end
                S_FILT1: begin
                    r_facc <= FACC_W'(gain_c) * FACC_W'(r_avg);
                end
                // second filter term, then present the read beat
                S_FILT2: begin
                    if (out_free) begin
                        r_smooth    <= MASS_W'(FACC_W'(r_facc +
                                       FACC_W'(GAIN_ONE - gain_c) * FACC_W'(r_smooth))
                                       >> GAIN_SH);
                        r_out_kind  <= 1'b1;
                        r_out_mass  <= MASS_W'((r_facc +
                                       FACC_W'(GAIN_ONE - gain_c) * FACC_W'(r_smooth))
                                       >> GAIN_SH);
                        r_out_acc   <= 1'b0;
                    end
                end
                default: ;
            endcase
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INITIAL_MASS: begin
                        r_held      <= i_cfg_data[MASS_W-1:0];
                        r_smooth    <= i_cfg_data[MASS_W-1:0];
                    end
                    CFG_THRESHOLD: r_thresh <= signed'(i_cfg_data);
                    CFG_GAIN:      r_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_WINDOW:    r_window <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.mass     = r_out_mass;
    assign o_out.accepted = r_out_acc;

    // checks
    `ASSERT_CLK(a_div_idle, div_start |-> !div_busy, "divider started while busy")
    `ASSERT_CLK(a_fill_max, r_fill <= FILL_W'(MAX_SAMPLES), "history fill overflow")
    `ASSERT_CLK(a_cnt_max, r_count <= CNT_W'(MAX_BATCH), "batch count overflow")
    `ASSERT_CLK(a_bout_hold, (r_state == S_BOUT) && r_out_valid && !o_out.ready |=> r_state == S_BOUT, "batch beat dropped")
    `ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> r_state == S_IDLE && !r_out_valid, "not idle after reset")
endmodule
`default_nettype wire
